>>> hw/rtl/cbspl_pkg.sv
// ----------------------------------------------------------------------------
// cbspl_pkg
// Shared types and constants for the cubic B-spline evaluator.
// ----------------------------------------------------------------------------
package cbspl_pkg;

   // coefficient table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int NUM_BANKS   = 4;
   localparam int BANK_DEPTH  = TABLE_DEPTH / NUM_BANKS;
   localparam int BANK_AW     = $clog2(BANK_DEPTH);

   // fixed-point formats
   localparam int FRAC_BITS   = 28;
   localparam int M_W         = 35;   // floor(x/h) at the widest shift
   localparam int W_W         = 31;   // basis weight, unsigned Q3.28
   localparam int OUT_W       = 40;

   // request opcodes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_EVAL   = 1'b1;

   // config register indexes
   localparam logic REG_STEP_SHIFT    = 1'b0;
   localparam logic REG_NUM_INTERVALS = 1'b1;

   localparam logic [4:0] STEP_SHIFT_RST    = 5'd0;
   localparam logic [9:0] NUM_INTERVALS_RST = 10'd1021;

   // one classified request, as it sits in the queue
   typedef struct packed {
      logic                   eval;     // 1: evaluate, 0: coefficient write
      logic                   wr_ok;    // write index lies inside the table
      logic [IDX_W-1:0]       index;    // write index, or m-1 for evaluate
      logic [31:0]            data;     // coefficient for a write
      logic [FRAC_BITS-1:0]   frac;     // t in Q0.28
      logic [3:0]             in_range; // per-tap index check
   } entry_type;

endpackage

>>> hw/rtl/cbspl_front.sv
// ----------------------------------------------------------------------------
// cbspl_front
// Classifies a request: splits x into interval and fraction, checks taps.
// ----------------------------------------------------------------------------
module cbspl_front (
   input  logic                  req_opcode,
   input  logic [9:0]            req_coeff_index,
   input  logic signed [31:0]    req_coeff_value,
   input  logic [31:0]           req_x_position,
   input  logic [4:0]            step_shift,
   input  logic [9:0]            num_intervals,
   output cbspl_pkg::entry_type  entry
);

   logic [62:0]                    scaled;
   logic [cbspl_pkg::M_W-1:0]      m_val;
   logic [35:0]                    m_ext;
   logic [35:0]                    n_lim;
   logic [35:0]                    d_lim;
   logic [35:0]                    lim;
   logic [35:0]                    tap;

   // x / h is a left shift; integer part from bit 28 up, fraction below
   always_comb begin
      scaled = {31'd0, req_x_position} << step_shift;
      m_val  = scaled[62:28];
      m_ext  = 36'(m_val);
      n_lim  = 36'(num_intervals) + 36'd2;
      d_lim  = 36'(cbspl_pkg::TABLE_DEPTH - 1);
      lim    = (n_lim < d_lim) ? n_lim : d_lim;
      tap    = '0;

      entry.eval  = (req_opcode == cbspl_pkg::OP_EVAL);
      entry.wr_ok = ({22'd0, req_coeff_index} < 32'(cbspl_pkg::TABLE_DEPTH));
      entry.data  = req_coeff_value;
      entry.frac  = scaled[27:0];
      entry.index = entry.eval ? (cbspl_pkg::IDX_W'(m_val) - cbspl_pkg::IDX_W'(1))
                               : cbspl_pkg::IDX_W'(req_coeff_index);

      // tap j reads index m-1+j; valid when 0 <= m-1+j <= lim
      for (int j = 0; j < 4; j++) begin
         tap = m_ext + 36'(j);
         entry.in_range[j] = (tap >= 36'd1) && (tap <= lim + 36'd1);
      end
   end

endmodule

>>> hw/rtl/cbspl_queue.sv
// ----------------------------------------------------------------------------
// cbspl_queue
// Four-entry queue between the classifying front and the evaluation back.
// ----------------------------------------------------------------------------
module cbspl_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cbspl_pkg::entry_type  push_entry,
   output logic                  not_full,
   input  logic                  pop,
   output logic                  not_empty,
   output cbspl_pkg::entry_type  head
);

   cbspl_pkg::entry_type slot_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   assign not_full  = (count_ff != 3'd4);
   assign not_empty = (count_ff != 3'd0);
   assign head      = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/cbspl_back.sv
// ----------------------------------------------------------------------------
// cbspl_back
// Banked coefficient table, basis weights, products, sum and rounding.
// ----------------------------------------------------------------------------
module cbspl_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  cbspl_pkg::entry_type           head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [cbspl_pkg::OUT_W-1:0] rsp_spline_value,
   output logic                           rsp_out_of_range
);

   localparam int FB = cbspl_pkg::FRAC_BITS;
   localparam int AW = cbspl_pkg::BANK_AW;
   localparam int IW = cbspl_pkg::IDX_W;

   logic adv;

   // four banks, index mod 4 picks the bank
   logic [31:0] mem [cbspl_pkg::NUM_BANKS][cbspl_pkg::BANK_DEPTH];
   logic [AW-1:0] raddr [4];
   logic [1:0]    rsel;
   logic [IW-1:0] rsum;
   logic          we;

   // stage 1: table read, squares
   logic          s1_valid_ff;
   logic [1:0]    s1_base_ff;
   logic [3:0]    s1_rng_ff;
   logic [31:0]   s1_rd_ff [4];
   logic [FB-1:0] s1_u_ff,  s1_u2_ff;
   logic [FB:0]   s1_v_ff,  s1_v2_ff;
   logic [FB:0]   v_in;
   logic [2*FB-1:0] uu;
   logic [2*FB+1:0] vv;

   // stage 2: cubes
   logic          s2_valid_ff;
   logic [1:0]    s2_base_ff;
   logic [3:0]    s2_rng_ff;
   logic [31:0]   s2_rd_ff [4];
   logic [FB-1:0] s2_u_ff, s2_u2_ff, s2_u3_ff;
   logic [FB:0]   s2_v_ff, s2_v2_ff, s2_v3_ff;
   logic [2*FB-1:0] uuu;
   logic [2*FB+1:0] vvv;

   // stage 3: weights and routed coefficients
   logic          s3_valid_ff;
   logic          s3_oor_ff;
   logic [cbspl_pkg::W_W-1:0] s3_w_ff [4];
   logic [33:0]   w_wide [4];
   logic signed [31:0] s3_c_ff [4];

   // stage 4: products
   logic          s4_valid_ff;
   logic          s4_oor_ff;
   logic signed [62:0] s4_p_ff [4];

   // stage 5: pair sums
   logic          s5_valid_ff;
   logic          s5_oor_ff;
   logic signed [63:0] s5_a_ff, s5_b_ff;
   logic signed [63:0] total;

   // output register
   logic          rsp_valid_ff;
   logic signed [cbspl_pkg::OUT_W-1:0] rsp_value_ff;
   logic          rsp_oor_ff;

   // whole pipe moves unless a finished result waits
   assign adv = !(rsp_valid_ff && !rsp_ready);
   assign pop = adv && head_valid;
   assign we  = pop && !head.eval && head.wr_ok;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_spline_value = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // per-bank read address: the tap j that lands in bank b
   always_comb begin
      rsel = '0;
      rsum = '0;
      for (int b = 0; b < 4; b++) begin
         rsel     = 2'(b) - head.index[1:0];
         rsum     = head.index + IW'(rsel);
         raddr[b] = rsum[IW-1:2];
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (we && head.index[1:0] == 2'(b)) begin
            mem[b][head.index[IW-1:2]] <= head.data;
         end
         if (adv) begin
            s1_rd_ff[b] <= mem[b][raddr[b]];
         end
      end
   end

   // squares of t and 1-t
   always_comb begin
      v_in = (FB+1)'(1) << FB;
      v_in = v_in - (FB+1)'(head.frac);
      uu   = head.frac * head.frac;
      vv   = v_in * v_in;
   end

   // cubes
   always_comb begin
      uuu = s1_u2_ff * s1_u_ff;
      vvv = s1_v2_ff * s1_v_ff;
   end

   // unnormalized B pieces, Q3.28
   always_comb begin
      w_wide[0] = 34'(s2_v3_ff);
      w_wide[1] = (34'd1 << FB) + 34'd3 * 34'(s2_v_ff) + 34'd3 * 34'(s2_v2_ff)
                  - 34'd3 * 34'(s2_v3_ff);
      w_wide[2] = (34'd1 << FB) + 34'd3 * 34'(s2_u_ff) + 34'd3 * 34'(s2_u2_ff)
                  - 34'd3 * 34'(s2_u3_ff);
      w_wide[3] = 34'(s2_u3_ff);
   end

   // final sum, round half up
   always_comb begin
      total = s5_a_ff + s5_b_ff + (64'sd1 <<< (FB - 1));
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_base_ff <= head.index[1:0];
         s1_rng_ff  <= head.in_range;
         s1_u_ff    <= head.frac;
         s1_v_ff    <= v_in;
         s1_u2_ff   <= uu[2*FB-1:FB];
         s1_v2_ff   <= vv[2*FB:FB];

         s2_base_ff <= s1_base_ff;
         s2_rng_ff  <= s1_rng_ff;
         s2_rd_ff   <= s1_rd_ff;
         s2_u_ff    <= s1_u_ff;
         s2_v_ff    <= s1_v_ff;
         s2_u2_ff   <= s1_u2_ff;
         s2_v2_ff   <= s1_v2_ff;
         s2_u3_ff   <= uuu[2*FB-1:FB];
         s2_v3_ff   <= vvv[2*FB:FB];

         s3_oor_ff  <= !(&s2_rng_ff);
         for (int j = 0; j < 4; j++) begin
            s3_w_ff[j] <= w_wide[j][cbspl_pkg::W_W-1:0];
            s3_c_ff[j] <= s2_rng_ff[j] ? s2_rd_ff[2'(j) + s2_base_ff] : 32'sd0;
         end

         s4_oor_ff  <= s3_oor_ff;
         for (int j = 0; j < 4; j++) begin
            s4_p_ff[j] <= s3_c_ff[j] * $signed({1'b0, s3_w_ff[j]});
         end

         s5_oor_ff  <= s4_oor_ff;
         s5_a_ff    <= 64'(s4_p_ff[0]) + 64'(s4_p_ff[1]);
         s5_b_ff    <= 64'(s4_p_ff[2]) + 64'(s4_p_ff[3]);

         rsp_value_ff <= cbspl_pkg::OUT_W'(total >>> FB);
         rsp_oor_ff   <= s5_oor_ff;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= head_valid && head.eval;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

endmodule

>>> hw/rtl/cubic_bspline_evaluator_unit.sv
// ----------------------------------------------------------------------------
// cubic_bspline_evaluator_unit
// Uniform cubic B-spline evaluator with a banked coefficient table.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | moves
//  req_     | in        | valid / ready      | coefficient write or evaluate request
//  rsp_     | out       | valid / ready      | spline value and range flag
//  csr_     | in        | APB setup + access | step_shift, num_intervals
//
// One request per cycle while no stalled result has filled the queue.
// The rate is set by the four-bank table: all four taps are read together, one per bank.
// Writes produce no result and pass through the same queue, keeping order.
// A stalled result freezes the back pipeline; the 4-entry queue keeps
// accepting until full. Synchronous reset clears control; the table is
// undefined until written.
// ----------------------------------------------------------------------------
module cubic_bspline_evaluator_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [9:0]            req_coeff_index,
   input  logic signed [31:0]    req_coeff_value,
   input  logic [31:0]           req_x_position,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [39:0]    rsp_spline_value,
   output logic                  rsp_out_of_range,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [4:0] step_shift_ff;
   logic [9:0] num_intervals_ff;
   logic       csr_wr;

   cbspl_pkg::entry_type front_entry;
   cbspl_pkg::entry_type head;
   logic                 q_not_full;
   logic                 q_not_empty;
   logic                 q_pop;
   logic                 push;

   // config registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_shift_ff    <= cbspl_pkg::STEP_SHIFT_RST;
         num_intervals_ff <= cbspl_pkg::NUM_INTERVALS_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            cbspl_pkg::REG_STEP_SHIFT:    step_shift_ff    <= csr_pwdata[4:0];
            cbspl_pkg::REG_NUM_INTERVALS: num_intervals_ff <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         cbspl_pkg::REG_STEP_SHIFT:    csr_prdata = 32'(step_shift_ff);
         cbspl_pkg::REG_NUM_INTERVALS: csr_prdata = 32'(num_intervals_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // front: classify
   assign req_ready = q_not_full;
   assign push      = req_valid && q_not_full;

   cbspl_front u_front (
      .req_opcode      (req_opcode),
      .req_coeff_index (req_coeff_index),
      .req_coeff_value (req_coeff_value),
      .req_x_position  (req_x_position),
      .step_shift      (step_shift_ff),
      .num_intervals   (num_intervals_ff),
      .entry           (front_entry)
   );

   cbspl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .not_full   (q_not_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (head)
   );

   // back: table and arithmetic
   cbspl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_not_empty),
      .head             (head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_spline_value (rsp_spline_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

>>> sim/tb_cubic_bspline_evaluator_unit.sv
// ----------------------------------------------------------------------------
// tb_cubic_bspline_evaluator_unit
// Self-checking bench for the cubic B-spline evaluator. Loads coefficients,
// evaluates positions across several grid steps and table sizes, and checks
// every spline value and range flag against an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module tb_cubic_bspline_evaluator_unit;

   localparam logic [2:0] ADDR_STEP_SHIFT    = 3'(4 * cbspl_pkg::REG_STEP_SHIFT);
   localparam logic [2:0] ADDR_NUM_INTERVALS = 3'(4 * cbspl_pkg::REG_NUM_INTERVALS);
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic signed [39:0] value;
      logic               oor;
   } spline_result_type;

   // predictor with its own table and register copies
   class spline_scoreboard;
      logic [31:0]       coeffs [cbspl_pkg::TABLE_DEPTH];
      bit                loaded [cbspl_pkg::TABLE_DEPTH];
      int unsigned       shift = 0;
      int unsigned       nint  = 1021;
      spline_result_type pending [$];
      int                errors = 0;
      int                evals = 0;
      int                writes = 0;
      int                oor_seen = 0;

      // floor(x/h); fractional part in Q0.28 through frac
      function longint cell_of(logic [31:0] x, output longint frac);
         if (shift <= cbspl_pkg::FRAC_BITS) begin
            frac = (longint'(x) & ((64'd1 << (cbspl_pkg::FRAC_BITS - shift)) - 1))
                   << shift;
            return longint'(x) >> (cbspl_pkg::FRAC_BITS - shift);
         end else begin
            frac = 0;
            return longint'(x) << (shift - cbspl_pkg::FRAC_BITS);
         end
      endfunction

      function bit tap_ok(longint idx);
         return idx >= 0 && idx <= longint'(nint) + 2 && idx < cbspl_pkg::TABLE_DEPTH;
      endfunction

      function void note_request(logic op, logic [9:0] idx, logic [31:0] val,
                                 logic [31:0] x);
         longint m, u, v, u2, u3, v2, v3, sum, k;
         longint w [4];
         spline_result_type r;
         if (op == cbspl_pkg::OP_WRITE) begin
            coeffs[idx] = val;
            loaded[idx] = 1;
            writes++;
            return;
         end
         m   = cell_of(x, u);
         v   = (64'd1 << cbspl_pkg::FRAC_BITS) - u;
         u2  = (u * u) >> cbspl_pkg::FRAC_BITS;
         u3  = (u2 * u) >> cbspl_pkg::FRAC_BITS;
         v2  = (v * v) >> cbspl_pkg::FRAC_BITS;
         v3  = (v2 * v) >> cbspl_pkg::FRAC_BITS;
         w[0] = v3;
         w[1] = (64'd1 << cbspl_pkg::FRAC_BITS) + 3 * v + 3 * v2 - 3 * v3;
         w[2] = (64'd1 << cbspl_pkg::FRAC_BITS) + 3 * u + 3 * u2 - 3 * u3;
         w[3] = u3;
         sum = 0;
         r.oor = 0;
         for (int j = 0; j < 4; j++) begin
            k = m - 1 + j;
            if (!tap_ok(k)) r.oor = 1;
            else sum += longint'($signed(coeffs[k])) * w[j];
         end
         // round half up into Q24.16
         r.value = 40'((sum + (64'sd1 << (cbspl_pkg::FRAC_BITS - 1)))
                       >>> cbspl_pkg::FRAC_BITS);
         pending.push_back(r);
         evals++;
         if (r.oor) oor_seen++;
      endfunction

      function void check_result(logic signed [39:0] value, logic oor);
         spline_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result value=%h oor=%b", $time, value, oor);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (value !== e.value) begin
            $display("%0t: spline_value expected %h actual %h", $time, e.value, value);
            errors++;
         end
         if (oor !== e.oor) begin
            $display("%0t: out_of_range expected %b actual %b", $time, e.oor, oor);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic               req_opcode = cbspl_pkg::OP_WRITE;
   logic [9:0]         req_coeff_index = '0;
   logic signed [31:0] req_coeff_value = '0;
   logic [31:0]        req_x_position = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [39:0] rsp_spline_value;
   logic               rsp_out_of_range;
   logic               csr_psel = 0;
   logic               csr_penable = 0;
   logic               csr_pwrite = 0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   spline_scoreboard sb = new();
   bit               stimulus_done = 0;
   int               csr_writes = 0;

   cubic_bspline_evaluator_unit i_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 5);
   endfunction

   // one request: optional idle gap, then hold until accepted
   task automatic send_request(logic op, logic [9:0] idx, logic [31:0] val,
                               logic [31:0] x);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1;
      req_opcode      <= op;
      req_coeff_index <= idx;
      req_coeff_value <= val;
      req_x_position  <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, idx, val, x);
   endtask

   // evaluate, first loading any in-table tap that was never written
   task automatic evaluate_at(logic [31:0] x);
      longint m, frac, k;
      m = sb.cell_of(x, frac);
      for (int j = 0; j < 4; j++) begin
         k = m - 1 + j;
         if (sb.tap_ok(k) && !sb.loaded[k])
            send_request(cbspl_pkg::OP_WRITE, 10'(k), $urandom, $urandom);
      end
      send_request(cbspl_pkg::OP_EVAL, 10'($urandom), $urandom, x);
   endtask

   // register write while the block is idle
   task automatic write_csr(logic [2:0] addr, logic [31:0] data);
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_STEP_SHIFT) sb.shift = data & 32'h1F;
      else if (addr == ADDR_NUM_INTERVALS) sb.nint = data & 32'h3FF;
      csr_writes++;
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   // position whose cell usually lands near the live part of the table
   function automatic logic [31:0] pick_position();
      longint m, fb, top;
      if ($urandom_range(9) == 0 || sb.shift > cbspl_pkg::FRAC_BITS) return $urandom;
      fb  = cbspl_pkg::FRAC_BITS - sb.shift;
      top = (64'd1 << (32 - fb)) - 1;
      m   = $urandom_range(sb.nint + 4);
      if ($urandom_range(5) == 0) m = $urandom_range(3);
      if (m > top) m = $urandom_range(32'(top));
      return 32'((m << fb) | (longint'($urandom) & ((64'd1 << fb) - 1)));
   endfunction

   // result side: random stalls, check on every accepted result
   initial begin
      int hold;
      hold = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_spline_value, rsp_out_of_range);
         if (hold > 0) hold--;
         else begin
            hold = pick_gap();
            rsp_ready <= (hold == 0) || ($urandom_range(3) == 0);
         end
      end
   end

   // main sequence
   initial begin
      int steps [6] = '{0, 20, 20, 9, 5, 14};
      int sizes [6] = '{1021, 1021, 1, 37, 1021, 513};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int p = 0; p < 6; p++) begin
         write_csr(ADDR_STEP_SHIFT, steps[p]);
         write_csr(ADDR_NUM_INTERVALS, sizes[p]);
         if (p == 0) begin
            // coefficient extremes, edge positions, full-scale fields
            send_request(cbspl_pkg::OP_WRITE, 10'd0, 32'h8000_0000, 32'hFFFF_FFFF);
            send_request(cbspl_pkg::OP_WRITE, 10'd1, 32'h7FFF_FFFF, 32'h0);
            send_request(cbspl_pkg::OP_WRITE, 10'd2, 32'h7FFF_FFFF, 32'h0);
            send_request(cbspl_pkg::OP_WRITE, 10'd3, 32'h8000_0000, 32'h0);
            send_request(cbspl_pkg::OP_WRITE, 10'd1023, 32'hFFFF_FFFF, 32'h0);
            send_request(cbspl_pkg::OP_WRITE, 10'd1022, 32'h0, 32'h0);
            evaluate_at(32'h0);
            evaluate_at(32'h1000_0000);
            evaluate_at(32'h1FFF_FFFF);
            evaluate_at(32'h1800_0000);
            evaluate_at(32'h0FFF_FFFF);
            evaluate_at(32'hFFFF_FFFF);
            evaluate_at(32'h2000_0001);
         end
         if (p == 1) begin
            // cells at the top of the table and beyond it
            evaluate_at(32'(1021 << 8));
            evaluate_at(32'(1022 << 8) | 32'hFF);
            evaluate_at(32'(1024 << 8));
            evaluate_at(32'hFFFF_FFFF);
         end
         for (int i = 0; i < 40; i++) begin
            if ($urandom_range(9) < 3)
               send_request(cbspl_pkg::OP_WRITE, 10'($urandom), $urandom, $urandom);
            else
               evaluate_at(pick_position());
         end
      end
      req_valid <= 0;
      stimulus_done = 1;
   end

   // wrap-up once everything has drained
   initial begin
      wait (stimulus_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d evaluations (%0d out of range), %0d coefficient writes,",
               sb.evals, sb.oor_seen, sb.writes);
      $display("and %0d register writes over six grid settings.", csr_writes);
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
